FILE: rtl/rtis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtis_pkg
// Shared types and constants for the rigid transform inlier scoring block.
// ----------------------------------------------------------------------------
package rtis_pkg;

	localparam int RTIS_MAX_POINTS = 1024;
	localparam int RTIS_QDEPTH     = 8;

	localparam int COORD_W = 24;
	localparam int ROT_W   = 18;
	localparam int ROW_W   = 54;
	localparam int SQ_W    = 54;
	localparam int SUM_W   = 64;
	localparam int IDX_W   = 10;
	localparam int TOT_W   = 11;

	// register indexes of the configuration port
	localparam logic [2:0] REG_ROT0    = 3'd0;
	localparam logic [2:0] REG_ROT1    = 3'd1;
	localparam logic [2:0] REG_ROT2    = 3'd2;
	localparam logic [2:0] REG_SHIFT_X = 3'd3;
	localparam logic [2:0] REG_SHIFT_Y = 3'd4;
	localparam logic [2:0] REG_SHIFT_Z = 3'd5;
	localparam logic [2:0] REG_MAX_SQ  = 3'd6;

	// identity rotation, one Q1.16 unit on the diagonal
	localparam logic [ROW_W-1:0] ROT0_RESET = ROW_W'(64'h1) << 16;
	localparam logic [ROW_W-1:0] ROT1_RESET = ROW_W'(64'h1) << 34;
	localparam logic [ROW_W-1:0] ROT2_RESET = ROW_W'(64'h1) << 52;

	// one scored pair on its way from the front to the back
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             inlier;
		logic [SQ_W-1:0]  sq;
		logic             done;
		logic [SUM_W-1:0] sum;
	} rec_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_WAIT
	} back_state_t;

endpackage
`default_nettype wire

FILE: rtl/rigid_transform_inlier_scoring_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rigid_transform_inlier_scoring_top
// Scores matched 3D point pairs against a configured rigid transform.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive a pair on src_*/dst_*/last_pair with push; it is taken
//   at a clock edge where push is high and full is low. One pair per cycle.
//   Result queue: while empty is low the oldest result sits on the result
//   ports; raise pop to take it. Exactly one result per pair, in order.
//   Configuration: write cfg_index/cfg_data with cfg_valid; cfg_ready is
//   always high. Write only while no pair is in flight.
// Path: an accepted pair passes four pipeline stages, the queue write and the
//   result register before its result sits on the ports. A pass-ending
//   pair with inliers also passes the bit-serial mean divider before its
//   result is loaded.
// Throughput: one pair per cycle, set by the pipelined multipliers. While the
//   divider runs the front keeps taking pairs until QDEPTH are in flight.
// Stall: when pop stays low the result register holds, the queue fills and
//   full rises; no result is dropped.
// Reset: arst_n clears the counters, queues and pipeline valids and loads
//   the identity rotation, zero translation and zero limit.
// ----------------------------------------------------------------------------
module rigid_transform_inlier_scoring_top import rtis_pkg::*; #(
	parameter int MAX_POINTS = RTIS_MAX_POINTS,
	parameter int QDEPTH     = RTIS_QDEPTH
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire  [2:0]                cfg_index,
	input  wire  [ROW_W-1:0]          cfg_data,
	input  wire                       push,
	output logic                      full,
	input  wire  signed [COORD_W-1:0] src_x,
	input  wire  signed [COORD_W-1:0] src_y,
	input  wire  signed [COORD_W-1:0] src_z,
	input  wire  signed [COORD_W-1:0] dst_x,
	input  wire  signed [COORD_W-1:0] dst_y,
	input  wire  signed [COORD_W-1:0] dst_z,
	input  wire                       last_pair,
	output logic                      empty,
	input  wire                       pop,
	output logic [IDX_W-1:0]          pair_index,
	output logic                      is_inlier,
	output logic [SQ_W-1:0]           pair_sq_dist,
	output logic                      pass_done,
	output logic [TOT_W-1:0]          inlier_total,
	output logic [SQ_W-1:0]           mean_sq_error
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int QW = $bits(rec_t) + CW;

	logic          f_push;
	rec_t          f_rec;
	logic [CW-1:0] f_cnt;
	logic [QW-1:0] q_rd_data;
	logic          q_empty;
	logic          q_pop;

	// front: config, transform and distance pipeline, running pass totals
	rtis_front #(
		.MAX_POINTS(MAX_POINTS),
		.QDEPTH    (QDEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.src_x    (src_x),
		.src_y    (src_y),
		.src_z    (src_z),
		.dst_x    (dst_x),
		.dst_y    (dst_y),
		.dst_z    (dst_z),
		.last_pair(last_pair),
		.q_push   (f_push),
		.q_rec    (f_rec),
		.q_cnt    (f_cnt),
		.q_pop    (q_pop)
	);

	// decouple: hold scored pairs while the divider is busy
	rtis_queue #(
		.WIDTH(QW),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wr_data({f_rec, f_cnt}),
		.pop    (q_pop),
		.rd_data(q_rd_data),
		.empty  (q_empty)
	);

	// back: mean on pass end, result register
	rtis_back #(
		.MAX_POINTS(MAX_POINTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (!q_empty),
		.q_rec        (rec_t'(q_rd_data[QW-1:CW])),
		.q_cnt        (q_rd_data[CW-1:0]),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.pair_index   (pair_index),
		.is_inlier    (is_inlier),
		.pair_sq_dist (pair_sq_dist),
		.pass_done    (pass_done),
		.inlier_total (inlier_total),
		.mean_sq_error(mean_sq_error)
	);

endmodule
`default_nettype wire

FILE: rtl/rtis_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtis_front
// Configuration registers, transform and distance pipeline, pass counters.
// ----------------------------------------------------------------------------
module rtis_front import rtis_pkg::*; #(
	parameter int MAX_POINTS = RTIS_MAX_POINTS,
	parameter int QDEPTH     = RTIS_QDEPTH,
	localparam int PW = $clog2(MAX_POINTS),
	localparam int CW = $clog2(MAX_POINTS + 1),
	localparam int OW = $clog2(QDEPTH + 1)
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire  [2:0]               cfg_index,
	input  wire  [ROW_W-1:0]         cfg_data,
	input  wire                      push,
	output logic                     full,
	input  wire  signed [COORD_W-1:0] src_x,
	input  wire  signed [COORD_W-1:0] src_y,
	input  wire  signed [COORD_W-1:0] src_z,
	input  wire  signed [COORD_W-1:0] dst_x,
	input  wire  signed [COORD_W-1:0] dst_y,
	input  wire  signed [COORD_W-1:0] dst_z,
	input  wire                      last_pair,
	output logic                     q_push,
	output rec_t                     q_rec,
	output logic [CW-1:0]            q_cnt,
	input  wire                      q_pop
);

	logic [ROW_W-1:0]          rot_q [3];
	logic signed [COORD_W-1:0] shift_q [3];
	logic [SQ_W-1:0]           max_sq_q;

	logic [PW-1:0]    pair_cnt_q;
	logic [CW-1:0]    inl_cnt_q;
	logic [SUM_W-1:0] err_sum_q;
	logic [OW-1:0]    occ_q;

	logic accept;
	logic done_in;
	logic signed [COORD_W-1:0] src [3];
	logic signed [COORD_W-1:0] dst [3];
	logic signed [41:0]        prod [3][3];

	logic                      v_s1, v_s2, v_s3, v_s4;
	logic signed [41:0]        p_s1 [3][3];
	logic signed [COORD_W-1:0] dst_s1 [3];
	logic [IDX_W-1:0]          idx_s1, idx_s2, idx_s3, idx_s4;
	logic                      done_s1, done_s2, done_s3, done_s4;
	logic signed [26:0]        d_s2 [3];
	logic [51:0]               sq_s3 [3];
	logic [SQ_W-1:0]           sq_s4;

	logic signed [26:0] d_nx [3];
	logic [51:0]        sq_nx [3];
	logic               inlier;
	logic [CW-1:0]      cnt_nx;
	logic [SUM_W-1:0]   sum_nx;

	assign cfg_ready = 1'b1;
	assign full      = (occ_q == OW'(QDEPTH));
	assign accept    = push && !full;
	assign done_in   = last_pair || (pair_cnt_q == PW'(MAX_POINTS - 1));

	assign src[0] = src_x;
	assign src[1] = src_y;
	assign src[2] = src_z;
	assign dst[0] = dst_x;
	assign dst[1] = dst_y;
	assign dst[2] = dst_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0]   <= ROT0_RESET;
			rot_q[1]   <= ROT1_RESET;
			rot_q[2]   <= ROT2_RESET;
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
			max_sq_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROT0:    rot_q[0]   <= cfg_data;
				REG_ROT1:    rot_q[1]   <= cfg_data;
				REG_ROT2:    rot_q[2]   <= cfg_data;
				REG_SHIFT_X: shift_q[0] <= $signed(cfg_data[COORD_W-1:0]);
				REG_SHIFT_Y: shift_q[1] <= $signed(cfg_data[COORD_W-1:0]);
				REG_SHIFT_Z: shift_q[2] <= $signed(cfg_data[COORD_W-1:0]);
				REG_MAX_SQ:  max_sq_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// rotation products, Q1.16 times Q7.16
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod[i][j] = $signed(rot_q[i][ROT_W*j +: ROT_W]) * src[j];
			end
		end
	end

	// round half up to Q.16, add translation, subtract target
	always_comb begin
		logic signed [42:0] r;
		logic signed [28:0] acc;
		for (int i = 0; i < 3; i++) begin
			acc = 29'(shift_q[i]) - 29'(dst_s1[i]);
			for (int j = 0; j < 3; j++) begin
				r   = 43'(p_s1[i][j]) + 43'sd32768;
				acc = acc + 29'($signed(r[42:16]));
			end
			d_nx[i] = acc[26:0];
		end
	end

	always_comb begin
		logic signed [53:0] m;
		for (int i = 0; i < 3; i++) begin
			m        = d_s2[i] * d_s2[i];
			sq_nx[i] = m[51:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		p_s1    <= prod;
		dst_s1  <= dst;
		idx_s1  <= IDX_W'(pair_cnt_q);
		done_s1 <= done_in;
		d_s2    <= d_nx;
		idx_s2  <= idx_s1;
		done_s2 <= done_s1;
		sq_s3   <= sq_nx;
		idx_s3  <= idx_s2;
		done_s3 <= done_s2;
		sq_s4   <= SQ_W'(sq_s3[0]) + SQ_W'(sq_s3[1]) + SQ_W'(sq_s3[2]);
		idx_s4  <= idx_s3;
		done_s4 <= done_s3;
	end

	assign inlier = (sq_s4 < max_sq_q);
	assign cnt_nx = inl_cnt_q + CW'(inlier);
	assign sum_nx = inlier ? (err_sum_q + SUM_W'(sq_s4)) : err_sum_q;

	// pass counters; clear at the end of a pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_cnt_q <= '0;
			inl_cnt_q  <= '0;
			err_sum_q  <= '0;
		end else begin
			if (accept) begin
				pair_cnt_q <= done_in ? '0 : pair_cnt_q + 1'b1;
			end
			if (v_s4) begin
				inl_cnt_q <= done_s4 ? '0 : cnt_nx;
				err_sum_q <= done_s4 ? '0 : sum_nx;
			end
		end
	end

	// credit for queue slots: every accepted pair owns one until popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (accept && !q_pop) begin
			occ_q <= occ_q + 1'b1;
		end else if (!accept && q_pop) begin
			occ_q <= occ_q - 1'b1;
		end
	end

	assign q_push       = v_s4;
	assign q_rec.idx    = idx_s4;
	assign q_rec.inlier = inlier;
	assign q_rec.sq     = sq_s4;
	assign q_rec.done   = done_s4;
	assign q_rec.sum    = sum_nx;
	assign q_cnt        = cnt_nx;

endmodule
`default_nettype wire

FILE: rtl/rtis_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtis_queue
// Small first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module rtis_queue import rtis_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = RTIS_QDEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW = $clog2(DEPTH + 1)
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [WIDTH-1:0] wr_data,
	input  wire              pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    cnt_q;
	logic             do_pop;

	assign empty   = (cnt_q == '0);
	assign do_pop  = pop && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/rtis_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtis_back
// Mean divider for pass-ending pairs and the result register.
// ----------------------------------------------------------------------------
module rtis_back import rtis_pkg::*; #(
	parameter int MAX_POINTS = RTIS_MAX_POINTS,
	localparam int CW = $clog2(MAX_POINTS + 1),
	localparam int SW = $clog2(SUM_W)
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               q_valid,
	input  wire  rec_t        q_rec,
	input  wire  [CW-1:0]     q_cnt,
	output logic              q_pop,
	output logic              empty,
	input  wire               pop,
	output logic [IDX_W-1:0]  pair_index,
	output logic              is_inlier,
	output logic [SQ_W-1:0]   pair_sq_dist,
	output logic              pass_done,
	output logic [TOT_W-1:0]  inlier_total,
	output logic [SQ_W-1:0]   mean_sq_error
);

	back_state_t state_q, state_d;

	logic             out_v_q;
	logic             out_free;
	logic             need_div;
	logic             load_direct, start_div, div_step, load_div;

	rec_t             hold_q;
	logic [CW-1:0]    div_q;
	logic [CW-1:0]    rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [SW-1:0]    step_q;

	logic [CW:0]      trial;
	logic             ge;
	logic [CW:0]      diff;

	assign out_free = !out_v_q || pop;
	assign need_div = q_rec.done && (q_cnt != '0);
	assign empty    = !out_v_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && out_free && need_div) state_d = BK_DIV;
			end
			BK_DIV: begin
				if (step_q == '0) state_d = BK_WAIT;
			end
			BK_WAIT: begin
				if (out_free) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop       = 1'b0;
		load_direct = 1'b0;
		start_div   = 1'b0;
		div_step    = 1'b0;
		load_div    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				q_pop       = q_valid && out_free;
				load_direct = q_pop && !need_div;
				start_div   = q_pop && need_div;
			end
			BK_DIV:  div_step = 1'b1;
			BK_WAIT: load_div = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	always_ff @(posedge clk) begin
		if (start_div) begin
			hold_q <= q_rec;
			div_q  <= q_cnt;
			rem_q  <= '0;
			quo_q  <= q_rec.sum;
			step_q <= SW'(SUM_W - 1);
		end else if (div_step) begin
			rem_q  <= ge ? diff[CW-1:0] : trial[CW-1:0];
			quo_q  <= {quo_q[SUM_W-2:0], ge};
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_direct || load_div) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			pair_index    <= q_rec.idx;
			is_inlier     <= q_rec.inlier;
			pair_sq_dist  <= q_rec.sq;
			pass_done     <= q_rec.done;
			inlier_total  <= q_rec.done ? TOT_W'(q_cnt) : '0;
			mean_sq_error <= q_rec.done ? '1 : '0;
		end else if (load_div) begin
			pair_index    <= hold_q.idx;
			is_inlier     <= hold_q.inlier;
			pair_sq_dist  <= hold_q.sq;
			pass_done     <= hold_q.done;
			inlier_total  <= TOT_W'(div_q);
			mean_sq_error <= quo_q[SQ_W-1:0];
		end
	end

endmodule
`default_nettype wire
